>>> rtl/tec_pkg.sv
// Shared types, constants and codes for the tach edge interval capture block
package tec_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_W       = 3;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PINS_W     = 8;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_FIRST_PIN     = 3'd4;

    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_BASE  = 2'd1;
    localparam logic [1:0] CMD_DUMP  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CH_IDX_W-1:0] ch;
        logic [TIME_W-1:0]   time_us;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] window_length_us;
        logic [CH_W-1:0]   first_pin;
    } cfg_t;

endpackage

>>> rtl/tec_if.sv
// Channel interfaces for input items and dump results
interface tec_in_if;
    logic                       valid;
    logic                       ready;
    logic [tec_pkg::OP_W-1:0]   op;
    logic [tec_pkg::PINS_W-1:0] pins;
    logic [tec_pkg::TIME_W-1:0] time_us;

    modport source (output valid, output op, output pins, output time_us, input ready);
    modport sink   (input valid, input op, input pins, input time_us, output ready);
endinterface

interface tec_out_if;
    logic                        valid;
    logic                        ready;
    logic [tec_pkg::CH_W-1:0]    channel;
    logic [tec_pkg::TIME_W-1:0]  interval_sum;
    logic [tec_pkg::COUNT_W-1:0] edge_count;
    logic                        last;

    modport source (output valid, output channel, output interval_sum, output edge_count,
                    output last, input ready);
    modport sink   (input valid, input channel, input interval_sum, input edge_count,
                    input last, output ready);
endinterface

>>> rtl/tach_edge_interval_capture.sv
// Top level: configuration registers and the front end, queue and back end
//
//  channel     dir  handshake      payload
//  sample_in   in   valid/ready    op, pins, time_us
//  result_out  out  valid/ready    channel, interval_sum, edge_count, last
//  apb         in   psel/penable   paddr, pwdata -> prdata
//
// Items are taken one per cycle while the two-entry command queue has room.
// Arm, sample and dump are classified in the cycle they are taken; an edge or
// baseline command updates channel state directly, a dump holds the back end for
// CHANNELS result transactions, one per cycle while result_out is ready.
// Reset is asynchronous and clears windows, baseline, edge times, sums and counts.
// A stalled result_out stops a dump in progress; sample_in stalls once the queue fills.
module tach_edge_interval_capture (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tec_pkg::ADDR_W-1:0]  paddr,
    input  logic [tec_pkg::DATA_W-1:0]  pwdata,
    output logic [tec_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    tec_in_if.sink                      sample_in,
    tec_out_if.source                   result_out
);

    logic [tec_pkg::TIME_W-1:0] window_length_reg;
    logic [tec_pkg::CH_W-1:0]   first_pin_reg;
    tec_pkg::cfg_t              cfg;
    logic                       cfg_write;

    logic          push_valid, push_ready;
    tec_pkg::cmd_t push_data;
    logic          pop_valid, pop_ready;
    tec_pkg::cmd_t pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign cfg.window_length_us = window_length_reg;
    assign cfg.first_pin        = first_pin_reg;

    always_comb
    begin
        if (paddr[2] == tec_pkg::ADDR_FIRST_PIN[2])
        begin
            prdata = {{(tec_pkg::DATA_W - tec_pkg::CH_W){1'b0}}, first_pin_reg};
        end
        else
        begin
            prdata = window_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= 32'd1000000;
            first_pin_reg     <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tec_pkg::ADDR_WINDOW_LENGTH[2])
            begin
                window_length_reg <= pwdata;
            end
            else
            begin
                first_pin_reg <= pwdata[tec_pkg::CH_W-1:0];
            end
        end
    end

    tec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .result_out (result_out)
    );

endmodule

>>> rtl/tec_front.sv
// Front end: window tracking, baseline and edge classification into commands
module tec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  tec_pkg::cfg_t      cfg,
    tec_in_if.sink             sample_in,
    output logic               push_valid,
    input  logic               push_ready,
    output tec_pkg::cmd_t      push_data
);

    logic                       window_open_reg, window_open_next;
    logic                       baseline_pending_reg, baseline_pending_next;
    logic [tec_pkg::TIME_W-1:0] window_start_reg, window_start_next;
    logic [tec_pkg::PINS_W-1:0] last_pins_reg, last_pins_next;

    logic                       accept;
    logic [tec_pkg::TIME_W-1:0] elapsed;
    logic [tec_pkg::PINS_W-1:0] diff;
    logic [tec_pkg::CH_W-1:0]   top_ch;
    logic                       emit;

    assign sample_in.ready = push_ready;
    assign accept          = sample_in.valid && push_ready;
    assign elapsed         = sample_in.time_us - window_start_reg;
    assign diff            = (sample_in.pins ^ last_pins_reg) >> cfg.first_pin;

    always_comb
    begin
        top_ch = '0;
        for (int i = 0; i < tec_pkg::PINS_W; i++)
        begin
            if (diff[i])
            begin
                top_ch = tec_pkg::CH_W'(i);
            end
        end
    end

    always_comb
    begin
        window_open_next      = window_open_reg;
        baseline_pending_next = baseline_pending_reg;
        window_start_next     = window_start_reg;
        last_pins_next        = last_pins_reg;
        emit                  = 1'b0;
        push_data.kind        = tec_pkg::CMD_EDGE;
        push_data.ch          = top_ch[tec_pkg::CH_IDX_W-1:0];
        push_data.time_us     = sample_in.time_us;
        unique case (sample_in.op)
            tec_pkg::OP_ARM:
            begin
                window_open_next      = 1'b1;
                window_start_next     = sample_in.time_us;
                baseline_pending_next = 1'b1;
            end
            tec_pkg::OP_SAMPLE:
            begin
                if (window_open_reg)
                begin
                    if (elapsed >= cfg.window_length_us)
                    begin
                        window_open_next = 1'b0;
                    end
                    else if (baseline_pending_reg)
                    begin
                        last_pins_next        = sample_in.pins;
                        baseline_pending_next = 1'b0;
                        push_data.kind        = tec_pkg::CMD_BASE;
                        emit                  = 1'b1;
                    end
                    else
                    begin
                        last_pins_next = sample_in.pins;
                        emit = (diff != '0) &&
                               ({1'b0, top_ch} < (tec_pkg::CH_W + 1)'(tec_pkg::CHANNELS));
                    end
                end
            end
            tec_pkg::OP_DUMP:
            begin
                push_data.kind = tec_pkg::CMD_DUMP;
                emit           = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign push_valid = sample_in.valid && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_open_reg      <= 1'b0;
            baseline_pending_reg <= 1'b0;
            window_start_reg     <= '0;
            last_pins_reg        <= '0;
        end
        else if (accept)
        begin
            window_open_reg      <= window_open_next;
            baseline_pending_reg <= baseline_pending_next;
            window_start_reg     <= window_start_next;
            last_pins_reg        <= last_pins_next;
        end
    end

endmodule

>>> rtl/tec_queue.sv
// Command queue between front end and back end
module tec_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tec_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tec_pkg::cmd_t pop_data
);

    localparam int PTR_W = (tec_pkg::QUEUE_DEPTH > 1) ? $clog2(tec_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tec_pkg::QUEUE_DEPTH + 1);

    tec_pkg::cmd_t    slot_reg [tec_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(tec_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(tec_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(tec_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(tec_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !do_pop)
        else $error("pop from empty queue");

endmodule

>>> rtl/tec_back.sv
// Back end: per-channel interval sums and counts, dump sequencing and result register
module tec_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  tec_pkg::cmd_t pop_data,
    tec_out_if.source     result_out
);

    logic [tec_pkg::TIME_W-1:0]  last_edge_time_reg [tec_pkg::CHANNELS];
    logic [tec_pkg::TIME_W-1:0]  sum_reg [tec_pkg::CHANNELS];
    logic [tec_pkg::COUNT_W-1:0] count_reg [tec_pkg::CHANNELS];
    logic [tec_pkg::CHANNELS-1:0] edge_seen_reg;

    logic                         dumping_reg;
    logic [tec_pkg::CH_IDX_W-1:0] dump_idx_reg;

    logic                        out_valid_reg;
    logic [tec_pkg::CH_W-1:0]    out_channel_reg;
    logic [tec_pkg::TIME_W-1:0]  out_sum_reg;
    logic [tec_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_last_reg;

    logic                         do_pop;
    logic                         out_free;
    logic                         out_load;
    logic                         load_last;
    logic [tec_pkg::CH_IDX_W-1:0] rd_idx;
    logic [tec_pkg::TIME_W-1:0]   rd_sum;
    logic [tec_pkg::COUNT_W-1:0]  rd_count;
    logic [tec_pkg::TIME_W-1:0]   delta;

    assign pop_ready = !dumping_reg;
    assign do_pop    = pop_valid && !dumping_reg;
    assign out_free  = !out_valid_reg || result_out.ready;
    assign out_load  = dumping_reg && out_free;
    assign load_last = dump_idx_reg == tec_pkg::CH_IDX_W'(tec_pkg::CHANNELS - 1);

    assign rd_idx   = dumping_reg ? dump_idx_reg : pop_data.ch;
    assign rd_sum   = sum_reg[rd_idx];
    assign rd_count = count_reg[rd_idx];
    assign delta    = pop_data.time_us - last_edge_time_reg[pop_data.ch];

    assign result_out.valid        = out_valid_reg;
    assign result_out.channel      = out_channel_reg;
    assign result_out.interval_sum = out_sum_reg;
    assign result_out.edge_count   = out_count_reg;
    assign result_out.last         = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tec_pkg::CHANNELS; i++)
            begin
                last_edge_time_reg[i] <= '0;
                sum_reg[i]            <= '0;
                count_reg[i]          <= '0;
            end
            edge_seen_reg <= '0;
            dumping_reg   <= 1'b0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                unique case (pop_data.kind)
                    tec_pkg::CMD_EDGE:
                    begin
                        if (edge_seen_reg[pop_data.ch])
                        begin
                            sum_reg[pop_data.ch] <= rd_sum + delta;
                            if (rd_count != '1)
                            begin
                                count_reg[pop_data.ch] <= rd_count + 1'b1;
                            end
                        end
                        else
                        begin
                            edge_seen_reg[pop_data.ch] <= 1'b1;
                        end
                        last_edge_time_reg[pop_data.ch] <= pop_data.time_us;
                    end
                    tec_pkg::CMD_BASE:
                    begin
                        edge_seen_reg <= '0;
                    end
                    tec_pkg::CMD_DUMP:
                    begin
                        dumping_reg  <= 1'b1;
                        dump_idx_reg <= '0;
                    end
                    default:
                    begin
                        dumping_reg <= 1'b0;
                    end
                endcase
            end
            if (out_load)
            begin
                sum_reg[dump_idx_reg]   <= '0;
                count_reg[dump_idx_reg] <= '0;
                if (load_last)
                begin
                    dumping_reg  <= 1'b0;
                    dump_idx_reg <= '0;
                end
                else
                begin
                    dump_idx_reg <= dump_idx_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_channel_reg <= tec_pkg::CH_W'(dump_idx_reg);
            out_sum_reg     <= rd_sum;
            out_count_reg   <= rd_count;
            out_last_reg    <= load_last;
        end
    end

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !dumping_reg |-> (dump_idx_reg == '0))
        else $error("dump index moved outside a dump");

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && load_last) |=> !dumping_reg)
        else $error("dump did not end after final channel");

    a_dump_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dumping_reg) |-> $past(do_pop && (pop_data.kind == tec_pkg::CMD_DUMP)))
        else $error("dump started without a dump command");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && (pop_data.kind == tec_pkg::CMD_EDGE) && (rd_count == '1))
        |=> (count_reg[$past(pop_data.ch)] == '1))
        else $error("edge count left saturation");

endmodule

>>> verif/tach_edge_interval_capture_test.sv
// Self-checking testbench for the tach edge interval capture block
module tach_edge_interval_capture_test;
    import tec_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [TIME_W-1:0]  interval_sum;
        logic [COUNT_W-1:0] edge_count;
        logic               last;
    } dump_entry_t;

    class interval_tracker;
        logic [TIME_W-1:0]  window_len;
        logic [CH_W-1:0]    pin_base;
        bit                 armed;
        bit                 need_base;
        logic [TIME_W-1:0]  window_begin;
        logic [PINS_W-1:0]  prev_pins;
        logic [TIME_W-1:0]  edge_stamp[CHANNELS];
        bit                 seen[CHANNELS];
        logic [TIME_W-1:0]  sum[CHANNELS];
        logic [COUNT_W-1:0] cnt[CHANNELS];
        dump_entry_t        dump_queue[$];
        int                 errors;

        function new();
            window_len = 32'd1000000;
            pin_base = '0;
            armed = 0;
            need_base = 0;
            window_begin = '0;
            prev_pins = '0;
            errors = 0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                edge_stamp[i] = '0;
                seen[i] = 0;
                sum[i] = '0;
                cnt[i] = '0;
            end
        endfunction

        function void record_item(logic [OP_W-1:0] op, logic [PINS_W-1:0] pins,
                                  logic [TIME_W-1:0] stamp);
            logic [PINS_W-1:0] diff;
            logic [TIME_W-1:0] elapsed;
            dump_entry_t       entry;
            int                ch;
            case (op)
                OP_ARM:
                begin
                    armed = 1;
                    window_begin = stamp;
                    need_base = 1;
                end
                OP_SAMPLE:
                begin
                    if (armed)
                    begin
                        elapsed = stamp - window_begin;
                        if (elapsed >= window_len)
                            armed = 0;
                        else if (need_base)
                        begin
                            prev_pins = pins;
                            need_base = 0;
                            for (int i = 0; i < CHANNELS; i++)
                                seen[i] = 0;
                        end
                        else
                        begin
                            diff = (pins ^ prev_pins) >> pin_base;
                            prev_pins = pins;
                            if (diff != '0)
                            begin
                                ch = 0;
                                for (int i = 0; i < PINS_W; i++)
                                    if (diff[i])
                                        ch = i;
                                if (ch < CHANNELS)
                                begin
                                    if (seen[ch])
                                    begin
                                        sum[ch] = sum[ch] + (stamp - edge_stamp[ch]);
                                        if (cnt[ch] != '1)
                                            cnt[ch] = cnt[ch] + 1'b1;
                                    end
                                    else
                                        seen[ch] = 1;
                                    edge_stamp[ch] = stamp;
                                end
                            end
                        end
                    end
                end
                OP_DUMP:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        entry.channel = CH_W'(i);
                        entry.interval_sum = sum[i];
                        entry.edge_count = cnt[i];
                        entry.last = (i == CHANNELS - 1);
                        dump_queue.push_back(entry);
                        sum[i] = '0;
                        cnt[i] = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(dump_entry_t got);
            dump_entry_t want;
            if (dump_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: channel %0d sum %0h count %0d last %0b",
                         $time, got.channel, got.interval_sum, got.edge_count, got.last);
            end
            else
            begin
                want = dump_queue.pop_front();
                if (got.channel !== want.channel || got.interval_sum !== want.interval_sum ||
                    got.edge_count !== want.edge_count || got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch: expected channel %0d sum %0h count %0d last %0b",
                             $time, want.channel, want.interval_sum, want.edge_count,
                             want.last);
                    $display("%0t:           actual   channel %0d sum %0h count %0d last %0b",
                             $time, got.channel, got.interval_sum, got.edge_count, got.last);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    tec_in_if  in_bus();
    tec_out_if out_bus();

    tach_edge_interval_capture dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (in_bus),
        .result_out (out_bus)
    );

    interval_tracker tracker;
    int              burst_left = 0;
    int              items_sent = 0;
    logic [31:0]     stall_bits = '1;
    int              stall_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_bits = '1;
                1: stall_bits = $urandom;
                2: stall_bits = $urandom | $urandom;
                default: stall_bits = $urandom & $urandom;
            endcase
            stall_left = 32;
        end
        out_bus.ready <= stall_bits[0];
        stall_bits = {stall_bits[0], stall_bits[31:1]};
        stall_left--;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            tracker.check_result('{channel: out_bus.channel, interval_sum: out_bus.interval_sum,
                                   edge_count: out_bus.edge_count, last: out_bus.last});
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [PINS_W-1:0] pins,
                             logic [TIME_W-1:0] stamp);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6))
                @(negedge clk) in_bus.valid <= 1'b0;
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        in_bus.valid <= 1'b1;
        in_bus.op <= op;
        in_bus.pins <= pins;
        in_bus.time_us <= stamp;
        do
            @(posedge clk);
        while (!in_bus.ready);
        tracker.record_item(op, pins, stamp);
        if (op != OP_SPARE)
            items_sent++;
    endtask

    // hold off until every dump transaction has drained, then let the back end settle
    task automatic drain_results();
        @(negedge clk) in_bus.valid <= 1'b0;
        burst_left = 0;
        while (tracker.dump_queue.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_WINDOW_LENGTH)
            tracker.window_len = data;
        else if (addr == ADDR_FIRST_PIN)
            tracker.pin_base = data[CH_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [TIME_W-1:0] window_len, logic [CH_W-1:0] pin_base);
        drain_results();
        write_reg(ADDR_WINDOW_LENGTH, window_len);
        write_reg(ADDR_FIRST_PIN, DATA_W'(pin_base));
    endtask

    task automatic run_window(int edges);
        logic [TIME_W-1:0] stamp;
        logic [PINS_W-1:0] levels;
        logic [PINS_W-1:0] flip;
        stamp = $urandom;
        send_item(OP_ARM, PINS_W'($urandom), stamp);
        stamp = stamp + $urandom_range(0, 50);
        levels = PINS_W'($urandom);
        send_item(OP_SAMPLE, levels, stamp);
        repeat (edges)
        begin
            case ($urandom_range(0, 9))
                0: stamp = stamp + $urandom;
                1: stamp = stamp + $urandom_range(0, 3);
                default: stamp = stamp + $urandom_range(1, 3000);
            endcase
            case ($urandom_range(0, 7))
                0: flip = PINS_W'($urandom);
                1: flip = '0;
                default: flip = 8'd1 << (tracker.pin_base +
                                         $urandom_range(0, PINS_W - 1 - tracker.pin_base));
            endcase
            levels = levels ^ flip;
            if ($urandom_range(0, 9) == 0)
                send_item(OP_DUMP, PINS_W'($urandom), $urandom);
            send_item(OP_SAMPLE, levels, stamp);
        end
    endtask

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("tach_edge_interval_capture_test: errors");
        $finish;
    end

    initial
    begin
        int                goal;
        tracker = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.op = OP_ARM;
        in_bus.pins = '0;
        in_bus.time_us = '0;
        out_bus.ready = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_item(OP_DUMP, 8'h5A, 32'h0000_0000);
        send_item(OP_SAMPLE, 8'hFF, 32'h0000_0000);
        send_item(OP_SPARE, 8'hA5, 32'hFFFF_FFFF);
        send_item(OP_ARM, 8'h00, 32'd100);
        send_item(OP_SAMPLE, 8'h00, 32'd150);
        send_item(OP_SAMPLE, 8'h00, 32'd200);
        send_item(OP_SAMPLE, 8'h01, 32'd300);
        send_item(OP_SAMPLE, 8'h00, 32'd500);
        send_item(OP_SAMPLE, 8'h80, 32'd600);
        send_item(OP_SAMPLE, 8'h7F, 32'd700);
        send_item(OP_ARM, 8'hFF, 32'd800);
        send_item(OP_SAMPLE, 8'hFF, 32'd810);
        send_item(OP_SAMPLE, 8'hFE, 32'd900);
        send_item(OP_SAMPLE, 8'hFF, 32'd1000);
        send_item(OP_SAMPLE, 8'hFE, 32'd1000800);
        send_item(OP_SAMPLE, 8'h00, 32'd1000900);
        send_item(OP_DUMP, 8'hFF, 32'hFFFF_FFFF);

        // wrap the timestamp and the interval sum
        configure('1, 3'd0);
        send_item(OP_ARM, 8'h00, 32'hFFFF_FF00);
        send_item(OP_SAMPLE, 8'h00, 32'hFFFF_FF10);
        send_item(OP_SAMPLE, 8'h40, 32'hFFFF_FF20);
        send_item(OP_SAMPLE, 8'h00, 32'h7FFF_FF20);
        send_item(OP_SAMPLE, 8'h40, 32'hFFFF_FF1F);
        send_item(OP_SAMPLE, 8'h00, 32'h7FFF_FF20);
        send_item(OP_DUMP, 8'h00, 32'h0000_0000);

        items_sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: configure('0, 3'd7);
                1: configure('1, 3'd0);
                2: configure(TIME_W'($urandom_range(500, 20000)), CH_W'($urandom_range(0, 7)));
                3: configure($urandom, CH_W'($urandom_range(0, 7)));
                default: configure(32'd1000000, CH_W'($urandom_range(0, 7)));
            endcase
            goal = items_sent + 12;
            while (items_sent < goal)
            begin
                case ($urandom_range(0, 9))
                    7: send_item(OP_DUMP, PINS_W'($urandom), $urandom);
                    8: send_item(OP_SAMPLE, PINS_W'($urandom), $urandom);
                    9: send_item(OP_SPARE, PINS_W'($urandom), $urandom);
                    default: run_window($urandom_range(2, 8));
                endcase
            end
            send_item(OP_DUMP, PINS_W'($urandom), $urandom);
        end

        drain_results();
        if (tracker.errors == 0)
            $display("tach_edge_interval_capture_test: clean");
        else
            $display("tach_edge_interval_capture_test: errors");
        $finish;
    end
endmodule
